>>> src/joystick_circle_to_square_unit_defines.svh
// assertion macros for the top-level rtl file
`ifndef JOYSTICK_CIRCLE_TO_SQUARE_UNIT_DEFINES_SVH
`define JOYSTICK_CIRCLE_TO_SQUARE_UNIT_DEFINES_SVH

// implication checked every cycle outside reset
`define JCS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jcs assertion failed");

// implication into the next cycle, also checked across reset
`define JCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("jcs assertion failed");

`endif

>>> src/jcs_pkg.sv
// ----------------------------------------------------------------------------
// jcs_pkg
// shared constants for the circle-to-square mapping pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jcs_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;

endpackage

>>> src/jcs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// jcs_sqrt_cell
// one digit of a restoring square root, registered, with side data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jcs_sqrt_cell #(
  parameter int SAMPLE_WIDTH = jcs_pkg::SAMPLE_WIDTH_DEF,
  parameter int SIDE_W       = 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [2*SAMPLE_WIDTH-1:0] in_rad,
  input  logic [SAMPLE_WIDTH+1:0]   in_rem,
  input  logic [SAMPLE_WIDTH-1:0]   in_root,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  output logic [2*SAMPLE_WIDTH-1:0] out_rad,
  output logic [SAMPLE_WIDTH+1:0]   out_rem,
  output logic [SAMPLE_WIDTH-1:0]   out_root,
  output logic [SIDE_W-1:0]         out_side
);

  localparam int W = SAMPLE_WIDTH;

  logic [W+3:0]   rem_t;
  logic [W+3:0]   trial;
  logic           ge;
  logic [W+3:0]   rem_d;
  logic           valid_r;
  logic [2*W-1:0] rad_r;
  logic [W+1:0]   rem_r;
  logic [W-1:0]   root_r;
  logic [SIDE_W-1:0] side_r;
  logic [2*W-1:0] rad_nxt;
  logic [W+1:0]   rem_nxt;
  logic [W-1:0]   root_nxt;

  always_comb begin
    rem_t    = {in_rem, in_rad[2*W-1:2*W-2]};
    trial    = {2'b00, in_root, 2'b01};
    ge       = (rem_t >= trial);
    rem_d    = ge ? (rem_t - trial) : rem_t;
    rem_nxt  = rem_d[W+1:0];
    root_nxt = {in_root[W-2:0], ge};
    rad_nxt  = {in_rad[2*W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_side  = side_r;

endmodule

>>> src/jcs_div_cell.sv
// ----------------------------------------------------------------------------
// jcs_div_cell
// one quotient bit of two restoring divisions sharing a divisor, registered
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jcs_div_cell #(
  parameter int SAMPLE_WIDTH = jcs_pkg::SAMPLE_WIDTH_DEF,
  parameter int SIDE_W       = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [SAMPLE_WIDTH:0]   in_den,
  input  logic [SAMPLE_WIDTH:0]   in_rem_x,
  input  logic [SAMPLE_WIDTH-1:0] in_lo_x,
  input  logic [SAMPLE_WIDTH-1:0] in_q_x,
  input  logic [SAMPLE_WIDTH:0]   in_rem_y,
  input  logic [SAMPLE_WIDTH-1:0] in_lo_y,
  input  logic [SAMPLE_WIDTH-1:0] in_q_y,
  input  logic [SIDE_W-1:0]       in_side,
  output logic                    out_valid,
  output logic [SAMPLE_WIDTH:0]   out_den,
  output logic [SAMPLE_WIDTH:0]   out_rem_x,
  output logic [SAMPLE_WIDTH-1:0] out_lo_x,
  output logic [SAMPLE_WIDTH-1:0] out_q_x,
  output logic [SAMPLE_WIDTH:0]   out_rem_y,
  output logic [SAMPLE_WIDTH-1:0] out_lo_y,
  output logic [SAMPLE_WIDTH-1:0] out_q_y,
  output logic [SIDE_W-1:0]       out_side
);

  localparam int W = SAMPLE_WIDTH;

  logic [W+1:0] tx, ty, dx, dy, den_e;
  logic         gex, gey;
  logic         valid_r;
  logic [W:0]   den_r, rem_x_r, rem_y_r;
  logic [W-1:0] lo_x_r, lo_y_r, q_x_r, q_y_r;
  logic [SIDE_W-1:0] side_r;
  logic [W:0]   rem_x_nxt, rem_y_nxt;

  always_comb begin
    den_e     = {1'b0, in_den};
    tx        = {in_rem_x, in_lo_x[W-1]};
    ty        = {in_rem_y, in_lo_y[W-1]};
    gex       = (tx >= den_e);
    gey       = (ty >= den_e);
    dx        = gex ? (tx - den_e) : tx;
    dy        = gey ? (ty - den_e) : ty;
    rem_x_nxt = dx[W:0];
    rem_y_nxt = dy[W:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r   <= in_den;
      rem_x_r <= rem_x_nxt;
      rem_y_r <= rem_y_nxt;
      lo_x_r  <= {in_lo_x[W-2:0], 1'b0};
      lo_y_r  <= {in_lo_y[W-2:0], 1'b0};
      q_x_r   <= {in_q_x[W-2:0], gex};
      q_y_r   <= {in_q_y[W-2:0], gey};
      side_r  <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_den   = den_r;
  assign out_rem_x = rem_x_r;
  assign out_lo_x  = lo_x_r;
  assign out_q_x   = q_x_r;
  assign out_rem_y = rem_y_r;
  assign out_lo_y  = lo_y_r;
  assign out_q_y   = q_y_r;
  assign out_side  = side_r;

endmodule

>>> src/joystick_circle_to_square_unit.sv
// ----------------------------------------------------------------------------
// joystick_circle_to_square_unit
// maps a joystick vector on the unit disc onto the enclosing square
// ----------------------------------------------------------------------------
// usage:
//   in_* beats carry one vector (stick_x, stick_y), signed Q1.(W-1).
//   out_* beats carry the mapped vector (square_x, square_y), same format,
//   saturated to +/-(2^(W-1)-1). one result beat per input beat, in order.
//   the path runs through registers a, b and c for magnitude and squaring,
//   one cell per root bit, registers d and e for scaling, one cell per
//   quotient bit of the division, and one output register.
//   throughput is one beat per cycle; every cell of the chain moves forward
//   in each cycle that the output register is free or being taken.
//   when out_tready is low with a beat held, the whole chain freezes and
//   in_tready drops in the same cycle; nothing is lost.
//   reset (rst_n low, synchronous) clears every valid flag; data is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "joystick_circle_to_square_unit_defines.svh"

module joystick_circle_to_square_unit #(
  parameter int SAMPLE_WIDTH = jcs_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // stick_x, stick_y, zero pad
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // square_x, square_y, zero pad
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    out_tdata
);

  localparam int W       = SAMPLE_WIDTH;
  localparam int TDATA_W = ((2*W+7)/8)*8;
  localparam int SQ_SIDE = 2*W+2;

  localparam logic [W-1:0] ONE    = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};

  logic en;

  // stage a: magnitudes
  logic [W-1:0] in_x, in_y, ax_c, ay_c;
  logic         a_valid_r;
  logic [W-1:0] a_ax_r, a_ay_r;
  logic         a_nx_r, a_ny_r;

  // stage b: squares
  logic           b_valid_r;
  logic [2*W-1:0] b_sqx_r, b_sqy_r;
  logic [W-1:0]   b_ax_r, b_ay_r;
  logic           b_nx_r, b_ny_r;

  // stage c: sum of squares
  logic           c_valid_r;
  logic [2*W-1:0] c_s_r;
  logic [W-1:0]   c_ax_r, c_ay_r;
  logic           c_nx_r, c_ny_r;

  // root chain
  logic               sq_valid [W+1];
  logic [2*W-1:0]     sq_rad   [W+1];
  logic [W+1:0]       sq_rem   [W+1];
  logic [W-1:0]       sq_root  [W+1];
  logic [SQ_SIDE-1:0] sq_side  [W+1];

  // stage d: clamp radius, products
  logic [W-1:0]   root_f, r_c, sd_ax, sd_ay, m_c;
  logic           sd_nx, sd_ny;
  logic           d_valid_r;
  logic [2*W-1:0] d_px_r, d_py_r;
  logic [W-1:0]   d_m_r;
  logic           d_nx_r, d_ny_r;

  // stage e: numerators and divisor
  logic [2*W:0] nx_c, ny_c;
  logic         e_valid_r;
  logic [2*W:0] e_nx_r, e_ny_r;
  logic [W:0]   e_den_r;
  logic [2:0]   e_side_r;

  // division chain
  logic         dv_valid [W+1];
  logic [W:0]   dv_den   [W+1];
  logic [W:0]   dv_rem_x [W+1];
  logic [W-1:0] dv_lo_x  [W+1];
  logic [W-1:0] dv_q_x   [W+1];
  logic [W:0]   dv_rem_y [W+1];
  logic [W-1:0] dv_lo_y  [W+1];
  logic [W-1:0] dv_q_y   [W+1];
  logic [2:0]   dv_side  [W+1];

  // output register
  logic [W-1:0] sat_x, sat_y, res_x_nxt, res_y_nxt;
  logic         out_valid_r;
  logic [W-1:0] res_x_r, res_y_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign in_x = in_tdata[W-1:0];
  assign in_y = in_tdata[2*W-1:W];
  // negating the most negative code gives 2^(W-1) as unsigned
  assign ax_c = in_x[W-1] ? (~in_x + 1'b1) : in_x;
  assign ay_c = in_y[W-1] ? (~in_y + 1'b1) : in_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= in_tvalid;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      d_valid_r   <= sq_valid[W];
      e_valid_r   <= d_valid_r;
      out_valid_r <= dv_valid[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ax_r  <= ax_c;
      a_ay_r  <= ay_c;
      a_nx_r  <= in_x[W-1];
      a_ny_r  <= in_y[W-1];
      b_sqx_r <= a_ax_r * a_ax_r;
      b_sqy_r <= a_ay_r * a_ay_r;
      b_ax_r  <= a_ax_r;
      b_ay_r  <= a_ay_r;
      b_nx_r  <= a_nx_r;
      b_ny_r  <= a_ny_r;
      c_s_r   <= b_sqx_r + b_sqy_r;
      c_ax_r  <= b_ax_r;
      c_ay_r  <= b_ay_r;
      c_nx_r  <= b_nx_r;
      c_ny_r  <= b_ny_r;
    end
  end

  assign sq_valid[0] = c_valid_r;
  assign sq_rad[0]   = c_s_r;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_side[0]  = {c_nx_r, c_ny_r, c_ax_r, c_ay_r};

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    jcs_sqrt_cell #(
      .SAMPLE_WIDTH(W),
      .SIDE_W      (SQ_SIDE)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (sq_valid[i]),
      .in_rad   (sq_rad[i]),
      .in_rem   (sq_rem[i]),
      .in_root  (sq_root[i]),
      .in_side  (sq_side[i]),
      .out_valid(sq_valid[i+1]),
      .out_rad  (sq_rad[i+1]),
      .out_rem  (sq_rem[i+1]),
      .out_root (sq_root[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  always_comb begin
    root_f = sq_root[W];
    {sd_nx, sd_ny, sd_ax, sd_ay} = sq_side[W];
    r_c = (root_f > ONE) ? ONE : root_f;
    m_c = (sd_ax > sd_ay) ? sd_ax : sd_ay;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_px_r <= sd_ax * r_c;
      d_py_r <= sd_ay * r_c;
      d_m_r  <= m_c;
      d_nx_r <= sd_nx;
      d_ny_r <= sd_ny;
    end
  end

  // 2*mag*r + m, rounding to nearest once divided by 2*m
  assign nx_c = {d_px_r, 1'b0} + {{(W+1){1'b0}}, d_m_r};
  assign ny_c = {d_py_r, 1'b0} + {{(W+1){1'b0}}, d_m_r};

  always_ff @(posedge clk) begin
    if (en) begin
      e_nx_r   <= nx_c;
      e_ny_r   <= ny_c;
      e_den_r  <= {d_m_r, 1'b0};
      e_side_r <= {d_nx_r, d_ny_r, (d_m_r == '0)};
    end
  end

  assign dv_valid[0] = e_valid_r;
  assign dv_den[0]   = e_den_r;
  assign dv_rem_x[0] = e_nx_r[2*W:W];
  assign dv_lo_x[0]  = e_nx_r[W-1:0];
  assign dv_q_x[0]   = '0;
  assign dv_rem_y[0] = e_ny_r[2*W:W];
  assign dv_lo_y[0]  = e_ny_r[W-1:0];
  assign dv_q_y[0]   = '0;
  assign dv_side[0]  = e_side_r;

  for (genvar i = 0; i < W; i++) begin : g_div
    jcs_div_cell #(
      .SAMPLE_WIDTH(W),
      .SIDE_W      (3)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (dv_valid[i]),
      .in_den   (dv_den[i]),
      .in_rem_x (dv_rem_x[i]),
      .in_lo_x  (dv_lo_x[i]),
      .in_q_x   (dv_q_x[i]),
      .in_rem_y (dv_rem_y[i]),
      .in_lo_y  (dv_lo_y[i]),
      .in_q_y   (dv_q_y[i]),
      .in_side  (dv_side[i]),
      .out_valid(dv_valid[i+1]),
      .out_den  (dv_den[i+1]),
      .out_rem_x(dv_rem_x[i+1]),
      .out_lo_x (dv_lo_x[i+1]),
      .out_q_x  (dv_q_x[i+1]),
      .out_rem_y(dv_rem_y[i+1]),
      .out_lo_y (dv_lo_y[i+1]),
      .out_q_y  (dv_q_y[i+1]),
      .out_side (dv_side[i+1])
    );
  end

  always_comb begin
    sat_x = (dv_q_x[W] > MAXPOS) ? MAXPOS : dv_q_x[W];
    sat_y = (dv_q_y[W] > MAXPOS) ? MAXPOS : dv_q_y[W];
    // zero vector: divisor was zero, quotient is meaningless
    if (dv_side[W][0]) begin
      sat_x = '0;
      sat_y = '0;
    end
    res_x_nxt = dv_side[W][2] ? (~sat_x + 1'b1) : sat_x;
    res_y_nxt = dv_side[W][1] ? (~sat_y + 1'b1) : sat_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_x_r <= res_x_nxt;
      res_y_r <= res_y_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-2*W){1'b0}}, res_y_r, res_x_r};

  `JCS_ASSERT_IMPL(a_x_not_min, out_valid_r, res_x_r != ONE)
  `JCS_ASSERT_IMPL(a_y_not_min, out_valid_r, res_y_r != ONE)
  `JCS_ASSERT_NEXT(a_reset_empties, !rst_n, !out_valid_r && !e_valid_r && !a_valid_r)

endmodule
